/* hdl/sorted_timestamp_row_table_defines.svh */
// Assertion helpers for the table RTL.
`ifndef SORTED_TIMESTAMP_ROW_TABLE_DEFINES_SVH
`define SORTED_TIMESTAMP_ROW_TABLE_DEFINES_SVH

`define STRT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define STRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/strt_pkg.sv */
package strt_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_MAX_CELLS   = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [63:0] NAN_PATTERN = 64'h7FF8_0000_0000_0000;
  localparam logic [3:0]  COLS_RESET  = 4'd8;

  typedef enum logic [2:0] {
    MODE_UPSERT = 3'd0,
    MODE_UPDATE = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_POP    = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_READ   = 3'd5,
    MODE_NOP6   = 3'd6,
    MODE_NOP7   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_OOB       = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_BAD_COL   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_RESOLVE,
    S_SHIFT_UP,
    S_INSERT,
    S_SHIFT_DOWN,
    S_READ_WAIT,
    S_MIN_ISSUE,
    S_MIN_TAKE,
    S_MAX_TAKE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] key;
    logic [2:0]  column;
    logic [63:0] cell_value;
    logic [7:0]  row_index;
    logic [8:0]  row_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  found_index;
    logic [31:0] read_key;
    logic [63:0] read_value;
    logic [8:0]  rows_held;
    logic [31:0] smallest_key;
    logic [31:0] largest_key;
  } rsp_t;

  typedef struct packed {
    mode_t       op;
    logic        col_bad;
    logic [31:0] key;
    logic [2:0]  column;
    logic [63:0] cell_value;
    logic [7:0]  row_index;
    logic [8:0]  row_count;
  } cmd_t;

endpackage

/* hdl/strt_chan_if.sv */
interface strt_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/strt_front.sv */
module strt_front #(
  parameter int MAX_CELLS = strt_pkg::DEF_MAX_CELLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  strt_chan_if.sink          req,
  output logic               push,
  output strt_pkg::cmd_t     push_cmd,
  input  logic               q_full
);
  import strt_pkg::*;

  localparam logic [6:0] MAXC = 7'(MAX_CELLS);

  logic [3:0] value_columns;
  logic [6:0] ncols;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_columns <= COLS_RESET;
    end else if (cfg_wr_en) begin
      value_columns <= cfg_wr_data;
    end
  end

  always_comb begin
    if (value_columns == 4'd0) begin
      ncols = 7'd1;
    end else if (7'(value_columns) > MAXC) begin
      ncols = MAXC;
    end else begin
      ncols = 7'(value_columns);
    end
  end

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    push_cmd.op         = mode_t'(req.payload.mode);
    push_cmd.col_bad    = 7'(req.payload.column) >= ncols;
    push_cmd.key        = req.payload.key;
    push_cmd.column     = req.payload.column;
    push_cmd.cell_value = req.payload.cell_value;
    push_cmd.row_index  = req.payload.row_index;
    push_cmd.row_count  = req.payload.row_count;
  end
endmodule

/* hdl/strt_queue.sv */
module strt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  strt_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  output strt_pkg::cmd_t pop_cmd,
  input  logic           pop
);
  import strt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;
  logic          do_pop;

  assign full      = cnt == CW'(QUEUE_DEPTH);
  assign pop_valid = cnt != '0;
  assign pop_cmd   = slots[rp];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end
endmodule

/* hdl/strt_engine.sv */
module strt_engine #(
  parameter int TABLE_DEPTH = strt_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_CELLS   = strt_pkg::DEF_MAX_CELLS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  strt_pkg::cmd_t q_cmd,
  output logic           pop,
  strt_chan_if.source    rsp
);
  import strt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int OW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = ((OW > 9) ? OW : 9) + 1;

  typedef struct packed {
    logic [31:0]                 key;
    logic [MAX_CELLS-1:0][63:0]  cells;
  } row_t;

  row_t mem [TABLE_DEPTH];
  row_t rd;

  state_t state, state_next;
  cmd_t   cmd;

  logic [OW-1:0] occ, occ_next;
  logic [OW-1:0] ra, ra_next;
  logic [AW-1:0] pa, pa_next;
  logic          pv, pv_next;
  logic          more, more_next;
  logic [OW-1:0] pos, pos_next;
  logic          match, match_next;
  row_t          row_q, row_q_next;
  status_t       status_q, status_next;
  logic [7:0]    fidx, fidx_next;
  logic [31:0]   rkey, rkey_next;
  logic [63:0]   rval, rval_next;
  logic [31:0]   kmin, kmin_next;
  logic [31:0]   kmax, kmax_next;
  logic          rsp_valid;
  rsp_t          rsp_data;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  row_t          mem_wd;
  logic [AW-1:0] mem_ra;

  logic          hit;
  logic [SW-1:0] del_end;
  logic          del_bad;
  logic          out_free;
  row_t          upd_row;
  row_t          new_row;
  logic [63:0]   rd_cell;

  assign hit      = pv && (rd.key >= cmd.key);
  assign del_end  = SW'(cmd.row_index) + SW'(cmd.row_count);
  assign del_bad  = (SW'(cmd.row_index) >= SW'(occ)) || (del_end > SW'(occ));
  assign out_free = !rsp_valid || rsp.ready;
  assign pop      = (state == S_IDLE);

  always_comb begin
    upd_row = row_q;
    new_row.key = cmd.key;
    rd_cell = '0;
    for (int j = 0; j < MAX_CELLS; j++) begin
      new_row.cells[j] = NAN_PATTERN;
      if (j[6:0] == 7'(cmd.column)) begin
        upd_row.cells[j] = cmd.cell_value;
        new_row.cells[j] = cmd.cell_value;
        rd_cell          = rd.cells[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd <= mem[mem_ra];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (cmd.op)
          MODE_UPSERT: state_next = cmd.col_bad ? S_MIN_ISSUE : S_SCAN;
          MODE_UPDATE: state_next = S_SCAN;
          MODE_FIND:   state_next = S_SCAN;
          MODE_DELETE: begin
            state_next = (del_bad || cmd.row_count == '0) ? S_MIN_ISSUE : S_SHIFT_DOWN;
          end
          MODE_READ: begin
            state_next = (SW'(cmd.row_index) >= SW'(occ) || cmd.col_bad) ?
                         S_MIN_ISSUE : S_READ_WAIT;
          end
          default: state_next = S_MIN_ISSUE;
        endcase
      end
      S_SCAN: begin
        if (hit || ra == occ) begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (cmd.op == MODE_UPSERT && !match && occ != OW'(TABLE_DEPTH)) begin
          state_next = (pos == occ) ? S_INSERT : S_SHIFT_UP;
        end else begin
          state_next = S_MIN_ISSUE;
        end
      end
      S_SHIFT_UP: begin
        if (!more) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT:     state_next = S_MIN_ISSUE;
      S_SHIFT_DOWN: begin
        if (!more && !pv) begin
          state_next = S_MIN_ISSUE;
        end
      end
      S_READ_WAIT:  state_next = S_MIN_ISSUE;
      S_MIN_ISSUE:  state_next = (occ == '0) ? S_DONE : S_MIN_TAKE;
      S_MIN_TAKE:   state_next = S_MAX_TAKE;
      S_MAX_TAKE:   state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    occ_next    = occ;
    ra_next     = ra;
    pa_next     = pa;
    pv_next     = pv;
    more_next   = more;
    pos_next    = pos;
    match_next  = match;
    row_q_next  = row_q;
    status_next = status_q;
    fidx_next   = fidx;
    rkey_next   = rkey;
    rval_next   = rval;
    kmin_next   = kmin;
    kmax_next   = kmax;
    mem_we      = 1'b0;
    mem_wa      = pa;
    mem_wd      = rd;
    mem_ra      = AW'(ra);
    case (state)
      S_IDLE: begin
        status_next = ST_OK;
        fidx_next   = '0;
        rkey_next   = '0;
        rval_next   = '0;
        ra_next     = '0;
        pv_next     = 1'b0;
      end
      S_DISPATCH: begin
        case (cmd.op)
          MODE_UPSERT: begin
            if (cmd.col_bad) begin
              status_next = ST_BAD_COL;
            end
          end
          MODE_DELETE: begin
            if (del_bad) begin
              status_next = ST_OOB;
            end else begin
              ra_next   = OW'(del_end);
              more_next = del_end < SW'(occ);
            end
          end
          MODE_POP: begin
            if (occ == '0) begin
              status_next = ST_EMPTY;
            end else begin
              occ_next = occ - 1'b1;
            end
          end
          MODE_READ: begin
            if (SW'(cmd.row_index) >= SW'(occ)) begin
              status_next = ST_OOB;
            end else if (cmd.col_bad) begin
              status_next = ST_BAD_COL;
            end
            mem_ra = AW'(cmd.row_index);
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (hit) begin
          pos_next   = OW'(pa);
          match_next = rd.key == cmd.key;
          row_q_next = rd;
        end else if (ra == occ) begin
          pos_next   = occ;
          match_next = 1'b0;
        end else begin
          pv_next = 1'b1;
          pa_next = AW'(ra);
          ra_next = ra + 1'b1;
        end
      end
      S_RESOLVE: begin
        mem_wa = AW'(pos);
        mem_wd = upd_row;
        ra_next   = occ - 1'b1;
        more_next = 1'b1;
        pv_next   = 1'b0;
        case (cmd.op)
          MODE_FIND: begin
            if (match) begin
              fidx_next = 8'(pos);
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          MODE_UPDATE: begin
            if (!match) begin
              status_next = ST_NOT_FOUND;
            end else if (cmd.col_bad) begin
              status_next = ST_BAD_COL;
            end else begin
              mem_we    = 1'b1;
              fidx_next = 8'(pos);
            end
          end
          MODE_UPSERT: begin
            if (match) begin
              mem_we    = 1'b1;
              fidx_next = 8'(pos);
            end else if (occ == OW'(TABLE_DEPTH)) begin
              status_next = ST_FULL;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        mem_we = pv;
        mem_wa = pa + 1'b1;
        if (more) begin
          pv_next   = 1'b1;
          pa_next   = AW'(ra);
          more_next = ra != pos;
          ra_next   = ra - 1'b1;
        end else begin
          pv_next = 1'b0;
        end
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(pos);
        mem_wd    = new_row;
        occ_next  = occ + 1'b1;
        fidx_next = 8'(pos);
      end
      S_SHIFT_DOWN: begin
        mem_we = pv;
        mem_wa = AW'(SW'(pa) - SW'(cmd.row_count));
        if (more) begin
          pv_next   = 1'b1;
          pa_next   = AW'(ra);
          more_next = (SW'(ra) + 1'b1) < SW'(occ);
          ra_next   = ra + 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            occ_next = occ - OW'(cmd.row_count);
          end
        end
      end
      S_READ_WAIT: begin
        fidx_next = cmd.row_index;
        rkey_next = rd.key;
        rval_next = rd_cell;
      end
      S_MIN_ISSUE: begin
        mem_ra = '0;
        if (occ == '0) begin
          kmin_next = '0;
          kmax_next = '0;
        end
      end
      S_MIN_TAKE: begin
        kmin_next = rd.key;
        mem_ra    = AW'(occ - 1'b1);
      end
      S_MAX_TAKE: begin
        kmax_next = rd.key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      pv        <= 1'b0;
      more      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      pv    <= pv_next;
      more  <= more_next;
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cmd <= q_cmd;
    end
    ra       <= ra_next;
    pa       <= pa_next;
    pos      <= pos_next;
    match    <= match_next;
    row_q    <= row_q_next;
    status_q <= status_next;
    fidx     <= fidx_next;
    rkey     <= rkey_next;
    rval     <= rval_next;
    kmin     <= kmin_next;
    kmax     <= kmax_next;
    if (state == S_DONE && out_free) begin
      rsp_data.status       <= status_q;
      rsp_data.found_index  <= fidx;
      rsp_data.read_key     <= rkey;
      rsp_data.read_value   <= rval;
      rsp_data.rows_held    <= 9'(occ);
      rsp_data.smallest_key <= kmin;
      rsp_data.largest_key  <= kmax;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;
endmodule

/* hdl/sorted_timestamp_row_table.sv */
// Sorted table of up to TABLE_DEPTH rows keyed by a 32-bit timestamp, each row holding
// MAX_CELLS 64-bit cells in one row-wide RAM with one write port and one read port.
// Commands are taken into a two-entry queue and run one at a time; every command returns
// exactly one response. Upsert, update and find run a linear key search. An insert or a
// range delete shifts the rows behind it. An insert shift starts where the search
// stopped, so search and shift together cover at most rows_held rows. The search and
// the shifts handle one row per cycle. Pop, read cell and commands rejected before the
// search do no key search. cfg_wr_data sets the number of value columns in use (0 acts
// as 1, values above MAX_CELLS clamp); the user must write it only when the block is
// idle, and the block itself does not enforce this.
module sorted_timestamp_row_table #(
  parameter int TABLE_DEPTH = strt_pkg::DEF_TABLE_DEPTH,
  parameter int MAX_CELLS   = strt_pkg::DEF_MAX_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  strt_chan_if.sink   req,
  strt_chan_if.source rsp
);
  import strt_pkg::*;

`include "sorted_timestamp_row_table_defines.svh"

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  strt_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .req(req), .push(push), .push_cmd(push_cmd), .q_full(q_full)
  );

  strt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop_valid(q_valid), .pop_cmd(q_cmd), .pop(pop)
  );

  strt_engine #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_CELLS(MAX_CELLS)) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop), .rsp(rsp)
  );

  `STRT_ASSERT_IMPL(a_rows_bound, rsp.valid, 32'(rsp.payload.rows_held) <= 32'(TABLE_DEPTH), "row count above depth")
  `STRT_ASSERT_IMPL(a_empty_keys, rsp.valid && rsp.payload.rows_held == 9'd0, rsp.payload.smallest_key == 32'd0 && rsp.payload.largest_key == 32'd0, "empty table reports keys")
  `STRT_ASSERT_IMPL(a_fail_index, rsp.valid && rsp.payload.status != ST_OK, rsp.payload.found_index == 8'd0 && rsp.payload.read_value == 64'd0, "failed transaction carries data")
  `STRT_ASSERT_NEXT(a_key_order, rsp.valid && rsp.payload.rows_held != 9'd0, rsp.payload.smallest_key <= rsp.payload.largest_key || !rsp.valid || $changed(rsp.payload), "key order broken")
endmodule
